[hdl/zsrt_pkg.sv]
// ----------------------------------------------------------------------------
// zsrt_pkg: shared types and constants of the zero-sample run trimmer
// Holds the word types of both channels, the job word that the front part
// hands to the back part, and the zero test on a y pattern.
// ----------------------------------------------------------------------------
package zsrt_pkg;

  // Width of the kept count on the result port.
  localparam int KEPT_COUNT_W = 16;
  // Default width of the internal saturating kept counter.
  localparam int COUNT_BITS_DEF = 16;
  // Samples held back at the start of a flanking profile.
  localparam int BUF_DEPTH = 3;
  // Candidate results one input word can release.
  localparam int SLOTS = BUF_DEPTH + 1;
  // Default number of jobs between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;
  // Width of the per-profile sample counter, and its saturated value.
  localparam int SEEN_W = 3;
  localparam logic [SEEN_W-1:0] SEEN_SAT = SEEN_W'(BUF_DEPTH + 1);
  localparam logic [SEEN_W-1:0] SEEN_BUF = SEEN_W'(BUF_DEPTH);
  // Magnitude bits of a double pattern.
  localparam logic [63:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

  // Input word.
  typedef struct packed {
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic        final_sample;
  } sample_t;

  // Result word.
  typedef struct packed {
    logic [63:0]             out_x;
    logic [63:0]             out_y;
    logic                    sample_valid;
    logic                    profile_end;
    logic [KEPT_COUNT_W-1:0] kept_count;
  } result_t;

  // One (x, y) pair.
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
  } pair_t;

  // Job word: the three held samples and the current one, in output order,
  // with a keep mask, the end-of-profile flag and the final count.
  typedef struct packed {
    pair_t [SLOTS-1:0]       slot;
    logic  [SLOTS-1:0]       keep;
    logic                    final_item;
    logic [KEPT_COUNT_W-1:0] count;
  } job_t;

  // Plus and minus zero both count as zero; NaN patterns count as nonzero.
  function automatic logic is_nonzero(input logic [63:0] y);
    return (y & MAG_MASK) != 64'd0;
  endfunction

endpackage

[hdl/zsrt_front.sv]
// ----------------------------------------------------------------------------
// zsrt_front: accepts samples and classifies them
// Keeps the look-ahead buffer and the profile state, decides which pending
// samples are kept, and issues one job word for every accepted sample.
// ----------------------------------------------------------------------------
module zsrt_front
  import zsrt_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  sample_t sample,
  input  logic    cfg_wr_en,
  input  logic    cfg_wr_data,
  input  logic    job_full,
  output logic    accept,
  output job_t    job
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Registers.
  logic                  keep_flanking;
  logic                  mode_flank;
  logic [SEEN_W-1:0]     samples_seen;
  logic                  before_pending_nonzero;
  logic [COUNT_BITS-1:0] kept_so_far;
  logic [63:0]           held_x [BUF_DEPTH];
  logic [63:0]           held_y [BUF_DEPTH];

  // Next values.
  logic                  mode_next;
  logic [SEEN_W-1:0]     samples_seen_next;
  logic                  before_pending_nonzero_next;
  logic [COUNT_BITS-1:0] kept_so_far_next;

  logic [SLOTS-1:0]      keep;
  logic [2:0]            keep_cnt;
  logic [COUNT_BITS:0]   kept_sum;
  logic                  z0, z1, z2, z3;
  logic                  last;

  assign accept = push && !job_full;
  assign last   = sample.final_sample;

  assign z0 = is_nonzero(held_y[0]);
  assign z1 = is_nonzero(held_y[1]);
  assign z2 = is_nonzero(held_y[2]);
  assign z3 = is_nonzero(sample.y_bits);

  // The mode is taken from the register on the first sample of a profile.
  assign mode_next = (samples_seen == '0) ? keep_flanking : mode_flank;

  // Keep decision for the held samples and the current one.
  always_comb begin
    keep = '0;
    if (!mode_next) begin
      keep[SLOTS-1] = z3;
    end else if (samples_seen < SEEN_BUF) begin
      // A short profile passes whole.
      if (last) begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
          keep[i] = SEEN_W'(i) < samples_seen;
        end
        keep[SLOTS-1] = 1'b1;
      end
    end else if (samples_seen == SEEN_BUF) begin
      keep[0] = z0 || z1;
      keep[1] = z0 || z1 || z2;
      keep[2] = z1 || z2 || z3;
      keep[3] = last && (z3 || z2);
    end else begin
      keep[0] = z0 || z3 || before_pending_nonzero;
      keep[3] = last && (z3 || z0);
    end
  end

  // Saturating kept count.
  always_comb begin
    keep_cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      keep_cnt = keep_cnt + 3'(keep[i]);
    end
    kept_sum = {1'b0, kept_so_far} + (COUNT_BITS + 1)'(keep_cnt);
    if (kept_sum > {1'b0, COUNT_MAX}) begin
      kept_so_far_next = COUNT_MAX;
    end else begin
      kept_so_far_next = kept_sum[COUNT_BITS-1:0];
    end
  end

  // Profile counters for the next sample.
  always_comb begin
    samples_seen_next           = samples_seen;
    before_pending_nonzero_next = before_pending_nonzero;
    if (samples_seen != SEEN_SAT) begin
      samples_seen_next = samples_seen + 1'b1;
    end
    if (mode_next && samples_seen == SEEN_BUF) begin
      before_pending_nonzero_next = z2;
    end else if (mode_next && samples_seen == SEEN_SAT) begin
      before_pending_nonzero_next = z0;
    end
    if (last) begin
      samples_seen_next           = '0;
      before_pending_nonzero_next = 1'b0;
    end
  end

  // Job word.
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      job.slot[i].x = held_x[i];
      job.slot[i].y = held_y[i];
    end
    job.slot[SLOTS-1].x = sample.x_bits;
    job.slot[SLOTS-1].y = sample.y_bits;
    job.keep            = keep;
    job.final_item      = last;
    job.count           = KEPT_COUNT_W'(kept_so_far_next);
  end

  // Configuration and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_flanking          <= 1'b1;
      mode_flank             <= 1'b1;
      samples_seen           <= '0;
      before_pending_nonzero <= 1'b0;
      kept_so_far            <= '0;
    end else begin
      if (cfg_wr_en) begin
        keep_flanking <= cfg_wr_data;
      end
      if (accept) begin
        mode_flank             <= mode_next;
        samples_seen           <= samples_seen_next;
        before_pending_nonzero <= before_pending_nonzero_next;
        kept_so_far            <= last ? '0 : kept_so_far_next;
      end
    end
  end

  // Look-ahead buffer; past the third sample only entry 0 is in use.
  always_ff @(posedge clk) begin
    if (accept && mode_next) begin
      if (samples_seen < SEEN_BUF) begin
        held_x[samples_seen[1:0]] <= sample.x_bits;
        held_y[samples_seen[1:0]] <= sample.y_bits;
      end else begin
        held_x[0] <= sample.x_bits;
        held_y[0] <= sample.y_bits;
      end
    end
  end

endmodule

[hdl/zsrt_queue.sv]
// ----------------------------------------------------------------------------
// zsrt_queue: job queue between front and back
// A short first-in first-out queue of job words; the head is visible
// without a pop.
// ----------------------------------------------------------------------------
module zsrt_queue
  import zsrt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output logic head_valid,
  output job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  job_t          entry [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign full       = fill == CW'(DEPTH);
  assign head_valid = fill != '0;
  assign head       = entry[rd_ptr];
  assign do_wr      = wr_en && !full;
  assign do_rd      = rd_en && head_valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_job;
    end
  end

endmodule

[hdl/zsrt_back.sv]
// ----------------------------------------------------------------------------
// zsrt_back: result sequencer
// Walks the keep mask of the job at the queue head and presents one result
// word per cycle while pop is high, adding an empty end marker where a
// profile's last job has nothing to send.
// ----------------------------------------------------------------------------
module zsrt_back
  import zsrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  job_t    head,
  output logic    head_pop,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  // Slots of the head job already delivered.
  logic [SLOTS-1:0] done;
  logic [SLOTS-1:0] done_next;

  logic [SLOTS-1:0] remain;
  logic [SLOTS-1:0] pick;
  logic [SLOTS-1:0] remain_after;
  logic             has_sample;
  logic             out_valid;
  logic             take;
  logic             is_end;
  logic [63:0]      sel_x;
  logic [63:0]      sel_y;

  assign remain     = head.keep & ~done;
  assign has_sample = remain != '0;

  // Lowest remaining slot goes out first.
  always_comb begin
    pick = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (remain[i]) begin
        pick = '0;
        pick[i] = 1'b1;
      end
    end
  end

  assign remain_after = remain & ~pick;

  // Pair selection from the chosen slot.
  always_comb begin
    sel_x = '0;
    sel_y = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel_x = sel_x | ({64{pick[i]}} & head.slot[i].x);
      sel_y = sel_y | ({64{pick[i]}} & head.slot[i].y);
    end
  end

  // Handshake and head retirement; a job with nothing to send is dropped.
  assign out_valid = head_valid && (has_sample || head.final_item);
  assign empty     = !out_valid;
  assign take      = pop && out_valid;
  assign is_end    = head.final_item && remain_after == '0;
  assign head_pop  = (head_valid && !out_valid) || (take && remain_after == '0);

  // Result word.
  always_comb begin
    result.out_x        = sel_x;
    result.out_y        = sel_y;
    result.sample_valid = has_sample;
    result.profile_end  = is_end;
    result.kept_count   = is_end ? head.count : '0;
  end

  always_comb begin
    done_next = done;
    if (head_pop) begin
      done_next = '0;
    end else if (take) begin
      done_next = done | pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else begin
      done <= done_next;
    end
  end

  // An empty marker always closes a profile.
  a_marker_ends: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.sample_valid) |-> result.profile_end)
    else $error("empty marker without profile end");

  // Only slots of the head job's keep mask are ever marked delivered.
  a_done_in_mask: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> ((done & ~head.keep) == '0))
    else $error("delivered slot outside keep mask");

  // Delivering the end of a profile retires the job and clears progress.
  a_end_retires: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && result.profile_end) |=> (done == '0))
    else $error("progress not cleared after profile end");

  // The head is retired only when there is one.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid)
    else $error("job retired from an empty queue");

endmodule

[hdl/zero_sample_run_trimmer_core.sv]
// ----------------------------------------------------------------------------
// zero_sample_run_trimmer_core: zero-sample run trimmer, top level
// Front part, job queue and result sequencer.
// ----------------------------------------------------------------------------
// A sample word is accepted in every cycle in which push is high and full is
// low; full rises only when QUEUE_DEPTH jobs wait between the classifier and
// the result sequencer. The sequencer delivers one result word per cycle
// while pop is high, so a sample that releases n results holds the queue
// head until all n are taken, while a job with nothing to send and no
// profile end is dropped. In flanking mode a profile's fourth sample
// releases up to four results at once; the queue absorbs such bursts while
// the average stays near one result per sample. There is no clearing pass
// after reset; the block is ready in the first cycle after rst falls.
// keep_flanking is sampled on the first sample of each profile.
module zero_sample_run_trimmer_core
  import zsrt_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  sample_t sample,
  input  logic    cfg_wr_en,
  input  logic    cfg_wr_data,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic accept;
  logic job_full;
  job_t job;
  logic head_valid;
  job_t head;
  logic head_pop;

  assign full = job_full;

  // Classifier.
  zsrt_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .sample      (sample),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .job_full    (job_full),
    .accept      (accept),
    .job         (job)
  );

  // Job queue.
  zsrt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept),
    .wr_job     (job),
    .full       (job_full),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Result sequencer.
  zsrt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule
